/* sv/ppmtg_pkg.sv */
// Package for the PPM pulse train generator.
// Holds shared widths, reset values, command and register codes.
// No dependencies.
package ppmtg_pkg;

	localparam int CHANNELS_DEF = 8;

	localparam int CMD_W   = 2;
	localparam int IDX_W   = 3;
	localparam int VALUE_W = 14;
	localparam int GAP_W   = 15;
	localparam int LEN_W   = 16;
	localparam int FNUM_W  = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_START = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_GAP_LEN     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_LEN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_LEVEL = 2'd2;

	localparam logic [VALUE_W-1:0] CENTER_VALUE = 14'd1500;
	localparam logic [GAP_W-1:0]   GAP_RESET    = 15'd300;
	localparam logic [LEN_W-1:0]   SYNC_RESET   = 16'd10000;

endpackage

/* sv/ppmtg_item_if.sv */
// Channel interfaces of the PPM pulse train generator: input item and result.
// Depends on ppmtg_pkg for field widths.
interface ppmtg_item_if;
	logic                              valid;
	logic                              ready;
	logic [ppmtg_pkg::CMD_W-1:0]       command;
	logic [ppmtg_pkg::IDX_W-1:0]       channel_index;
	logic [ppmtg_pkg::VALUE_W-1:0]     channel_value;

	modport source (output valid, command, channel_index, channel_value, input ready);
	modport sink (input valid, command, channel_index, channel_value, output ready);
endinterface

interface ppmtg_result_if;
	logic                              valid;
	logic                              ready;
	logic                              ppm_level;
	logic                              busy_res;
	logic [ppmtg_pkg::FNUM_W-1:0]      frame_number;
	logic                              frame_end;

	modport source (output valid, ppm_level, busy_res, frame_number, frame_end, input ready);
	modport sink (input valid, ppm_level, busy_res, frame_number, frame_end, output ready);
endinterface

/* sv/ppm_train_generator_core.sv */
// PPM pulse train generator: channel table in RAM, tick counter and frame sequencer.
// Items pass the execute and output registers; one item per cycle unless stalled.
// The RAM is read in the accept cycle; the item executes when the output is free.
// Reset: asynchronous, clears control state and table valid bits; an unwritten
// table entry reads as the center value 1500, so there is no clearing pass.
// Depends on ppmtg_pkg, ppmtg_item_if, ppmtg_result_if, ppmtg_ram.
module ppm_train_generator_core #(
	parameter int CHANNELS = ppmtg_pkg::CHANNELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	ppmtg_item_if.sink                          item,
	ppmtg_result_if.source                      result,
	input  logic                                cfg_we,
	input  logic [ppmtg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ppmtg_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int FC_W = ($clog2(CHANNELS + 3) > ppmtg_pkg::FNUM_W) ?
		$clog2(CHANNELS + 3) : ppmtg_pkg::FNUM_W;
	localparam int LW = ppmtg_pkg::LEN_W;
	localparam logic [FC_W-1:0] F_SYNC = FC_W'(CHANNELS);
	localparam logic [FC_W-1:0] F_IDLE = FC_W'(CHANNELS + 1);
	localparam logic [FC_W-1:0] F_STOP = FC_W'(CHANNELS + 2);

	// configuration
	logic [ppmtg_pkg::GAP_W-1:0] gap_q;
	logic [LW-1:0]               sync_q;
	logic                        plevel_q;

	// train state
	logic [LW-1:0]   tick_q, period_q;
	logic [FC_W-1:0] fc_q;
	logic            run_q, conn_q;
	logic            vld_q [CHANNELS];

	// execute stage
	logic                            s1_valid_q;
	logic [ppmtg_pkg::CMD_W-1:0]     cmd_s1;
	logic [ppmtg_pkg::IDX_W-1:0]     idx_s1;
	logic [ppmtg_pkg::VALUE_W-1:0]   val_s1;
	logic                            rd_vld_s1;
	logic                            fwd_hit_s1;
	logic [ppmtg_pkg::VALUE_W-1:0]   fwd_data_s1;

	// output register
	logic                    out_valid_q;
	logic                    lvl_q, busy_q, fend_q;
	logic [ppmtg_pkg::FNUM_W-1:0] fnum_q;

	logic                          adv_s1, accept;
	logic [ppmtg_pkg::VALUE_W-1:0] ram_rdata, tab_val;
	logic [LW:0]                   tick_inc;
	logic [LW-1:0]                 load_len;
	logic [LW-1:0]                 tick_d, period_d;
	logic [FC_W-1:0]               fc_d, src_fc;
	logic                          run_d, conn_d, end_d;
	logic                          ram_we, idx_ok;
	logic [AW-1:0]                 waddr, raddr;

	assign adv_s1 = s1_valid_q & (~out_valid_q | result.ready);
	assign item.ready = ~s1_valid_q | adv_s1;
	assign accept = item.valid & item.ready;

	assign tab_val = fwd_hit_s1 ? fwd_data_s1 :
		(rd_vld_s1 ? ram_rdata : ppmtg_pkg::CENTER_VALUE);
	assign load_len = LW'(tab_val) + LW'(gap_q);
	assign tick_inc = {1'b0, tick_q} + (LW+1)'(1);
	assign idx_ok = ({2'b00, idx_s1} < (ppmtg_pkg::IDX_W+2)'(CHANNELS));
	assign waddr = AW'(idx_s1);
	assign ram_we = adv_s1 & (cmd_s1 == ppmtg_pkg::CMD_WRITE) & idx_ok;

	always_comb begin
		tick_d = tick_q;
		period_d = period_q;
		fc_d = fc_q;
		run_d = run_q;
		conn_d = conn_q;
		end_d = 1'b0;
		case (cmd_s1)
			ppmtg_pkg::CMD_TICK: begin
				if (run_q) begin
					if (tick_inc >= {1'b0, period_q}) begin
						end_d = 1'b1;
						tick_d = '0;
						if (fc_q == F_STOP) begin
							run_d = 1'b0;
						end else begin
							if (fc_q == F_IDLE) begin
								conn_d = 1'b0;
							end else if (fc_q == F_SYNC) begin
								period_d = sync_q;
							end else if (fc_q < F_SYNC) begin
								period_d = load_len;
							end
							fc_d = fc_q + FC_W'(1);
						end
					end else begin
						tick_d = tick_inc[LW-1:0];
					end
				end
			end
			ppmtg_pkg::CMD_START: begin
				run_d = 1'b1;
				conn_d = 1'b1;
				fc_d = FC_W'(1);
				tick_d = '0;
				period_d = load_len;
			end
			default: ;
		endcase
	end

	// read address for the incoming beat follows the frame counter after the
	// item now executing
	always_comb begin
		src_fc = adv_s1 ? fc_d : fc_q;
		if (item.command == ppmtg_pkg::CMD_START) begin
			raddr = '0;
		end else if (src_fc < F_SYNC) begin
			raddr = src_fc[AW-1:0];
		end else begin
			raddr = '0;
		end
	end

	ppmtg_ram #(
		.WIDTH(ppmtg_pkg::VALUE_W),
		.DEPTH(CHANNELS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (val_s1),
		.re    (accept),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= ppmtg_pkg::GAP_RESET;
			sync_q <= ppmtg_pkg::SYNC_RESET;
			plevel_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				ppmtg_pkg::REG_GAP_LEN:     gap_q <= cfg_data[ppmtg_pkg::GAP_W-1:0];
				ppmtg_pkg::REG_SYNC_LEN:    sync_q <= cfg_data;
				ppmtg_pkg::REG_PULSE_LEVEL: plevel_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			period_q <= ppmtg_pkg::SYNC_RESET;
			fc_q <= '0;
			run_q <= 1'b0;
			conn_q <= 1'b0;
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			if (adv_s1) begin
				tick_q <= tick_d;
				period_q <= period_d;
				fc_q <= fc_d;
				run_q <= run_d;
				conn_q <= conn_d;
			end
			if (ram_we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (adv_s1) begin
				s1_valid_q <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload of the execute stage; forward a write that lands in the read cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= item.command;
			idx_s1 <= item.channel_index;
			val_s1 <= item.channel_value;
			rd_vld_s1 <= vld_q[raddr];
			fwd_hit_s1 <= ram_we & (waddr == raddr);
			fwd_data_s1 <= val_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			if (!conn_d) begin
				lvl_q <= 1'b1;
			end else if (tick_d < LW'(gap_q)) begin
				lvl_q <= plevel_q;
			end else begin
				lvl_q <= ~plevel_q;
			end
			busy_q <= run_d;
			fnum_q <= fc_d[ppmtg_pkg::FNUM_W-1:0];
			fend_q <= end_d;
		end
	end

	assign result.valid = out_valid_q;
	assign result.ppm_level = lvl_q;
	assign result.busy_res = busy_q;
	assign result.frame_number = fnum_q;
	assign result.frame_end = fend_q;

endmodule

/* sv/ppmtg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppmtg_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for ppm_train_generator_core: directed table, then random pulse trains
// checked against a cycle-free predictor of the frame sequencer and pin level.
// Depends on ppmtg_pkg, ppmtg_item_if, ppmtg_result_if and the core itself.
module tb_top;
	import ppmtg_pkg::*;

	localparam int CHANNELS = CHANNELS_DEF;
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam longint LIMIT_NS = 5_000_000;

	typedef struct packed {
		logic              ppm_level;
		logic              busy_res;
		logic [FNUM_W-1:0] frame_number;
		logic              frame_end;
	} ppm_result_t;

	typedef struct {
		logic [CMD_W-1:0]   cmd;
		logic [IDX_W-1:0]   idx;
		logic [VALUE_W-1:0] val;
		bit                 fixed;
		ppm_result_t        want;
	} ppm_beat_t;

	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  sel;
		logic [CFG_DATA_W-1:0] rval;
		logic [CMD_W-1:0]      cmd;
		logic [IDX_W-1:0]      idx;
		logic [VALUE_W-1:0]    val;
		bit                    fixed;
		ppm_result_t           want;
	} dir_row_t;

	localparam ppm_result_t IDLE_PIN = '{1'b1, 1'b0, 4'd0, 1'b0};
	localparam ppm_result_t NO_PIN   = '0;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ppmtg_item_if   item_ch ();
	ppmtg_result_if result_ch ();

	ppm_train_generator_core #(.CHANNELS(CHANNELS)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state
	logic [VALUE_W-1:0] tbl_len [CHANNELS];
	logic [LEN_W-1:0]   cur_tick;
	logic [LEN_W-1:0]   cur_period;
	int unsigned        frame_idx;
	bit                 trk_run;
	bit                 trk_conn;
	logic [GAP_W-1:0]   gap_reg;
	logic [LEN_W-1:0]   sync_reg;
	logic               pol_reg;

	// table contents as the stimulus will leave them, for sizing trains
	int unsigned sched_tbl [CHANNELS];

	ppm_beat_t   pending_beats [$];
	ppm_result_t train_exp_q [$];

	int n_err = 0;
	int n_beats = 0;
	int n_results = 0;
	int n_bounds = 0;
	int n_starts = 0;
	int n_trains = 0;
	int n_cfg = 0;

	int burst_left = 8;
	int gap_left = 0;
	bit beat_take;
	bit beat_hold;
	ppm_result_t beat_pred;
	ppm_result_t seen;
	ppm_result_t want_r;

	int rdy_age = 0;
	int rdy_span = 64;
	int rdy_mode = 0;
	int rdy_per = 3;
	bit rdy_next;
	bit hold_on = 1'b0;
	int hold_req = 0;
	int hold_seen = 0;

	dir_row_t dir_tab [23];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("tb_top: timeout with %0d beats queued, %0d results outstanding",
			pending_beats.size(), train_exp_q.size());
		$display("tb_top: done, errors");
		$finish;
	end

	function automatic ppm_result_t advance_encoder(input logic [CMD_W-1:0] cmd,
			input logic [IDX_W-1:0] idx, input logic [VALUE_W-1:0] val);
		ppm_result_t r;
		int unsigned nxt;
		int unsigned f;
		r.frame_end = 1'b0;
		case (cmd)
			CMD_TICK: begin
				if (trk_run) begin
					nxt = int'(cur_tick) + 1;
					// a zero period behaves as one tick
					if (nxt >= int'(cur_period)) begin
						f = frame_idx;
						cur_tick = '0;
						r.frame_end = 1'b1;
						if (f == CHANNELS + 2) begin
							trk_run = 1'b0;
							n_trains++;
						end else begin
							if (f == CHANNELS + 1)
								trk_conn = 1'b0;
							else if (f == CHANNELS)
								cur_period = sync_reg;
							else if (f < CHANNELS)
								cur_period = LEN_W'(tbl_len[f]) + LEN_W'(gap_reg);
							frame_idx = f + 1;
						end
					end else begin
						cur_tick = nxt[LEN_W-1:0];
					end
				end
			end
			CMD_WRITE: begin
				if (int'(idx) < CHANNELS)
					tbl_len[idx] = val;
			end
			CMD_START: begin
				trk_run = 1'b1;
				trk_conn = 1'b1;
				frame_idx = 1;
				cur_tick = '0;
				cur_period = LEN_W'(tbl_len[0]) + LEN_W'(gap_reg);
			end
			default: ;
		endcase
		if (!trk_conn)
			r.ppm_level = 1'b1;
		else if (cur_tick < LEN_W'(gap_reg))
			r.ppm_level = pol_reg;
		else
			r.ppm_level = ~pol_reg;
		r.busy_res = trk_run;
		r.frame_number = frame_idx[FNUM_W-1:0];
		return r;
	endfunction

	function automatic void queue_beat(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
			input logic [VALUE_W-1:0] val, input bit fixed, input ppm_result_t want);
		ppm_beat_t b;
		b.cmd = cmd;
		b.idx = idx;
		b.val = val;
		b.fixed = fixed;
		b.want = want;
		if (cmd == CMD_WRITE && int'(idx) < CHANNELS)
			sched_tbl[idx] = val;
		pending_beats.push_back(b);
	endfunction

	// sender: bursts of random length, random gaps; hold payload while stalled
	always @(posedge clk) begin
		if (arst_n) begin
			beat_take = item_ch.valid && item_ch.ready;
			beat_hold = item_ch.valid && !item_ch.ready;
			if (beat_take) begin
				beat_pred = advance_encoder(item_ch.command, item_ch.channel_index,
					item_ch.channel_value);
				if (pending_beats[0].fixed)
					beat_pred = pending_beats[0].want;
				train_exp_q.push_back(beat_pred);
				n_beats++;
				if (item_ch.command == CMD_START)
					n_starts++;
				if (beat_pred.frame_end)
					n_bounds++;
				pending_beats.delete(0);
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 32);
					gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
				end
			end else if (!item_ch.valid && gap_left > 0) begin
				gap_left--;
			end
			if (!beat_hold) begin
				if (gap_left == 0 && pending_beats.size() > 0) begin
					item_ch.valid <= 1'b1;
					item_ch.command <= pending_beats[0].cmd;
					item_ch.channel_index <= pending_beats[0].idx;
					item_ch.channel_value <= pending_beats[0].val;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern changes after a random span
	always @(posedge clk) begin
		rdy_age++;
		if (rdy_age >= rdy_span) begin
			rdy_age = 0;
			rdy_span = $urandom_range(32, 256);
			rdy_mode = $urandom_range(0, 2);
			rdy_per = $urandom_range(2, 7);
		end
		case (rdy_mode)
			0: rdy_next = 1'b1;
			1: rdy_next = (rdy_age % rdy_per) != 0;
			default: rdy_next = $urandom_range(0, 9) < 7;
		endcase
		result_ch.ready <= rdy_next && !hold_on;
	end

	// long receiver hold-off, on request from the stimulus
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_on <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_on <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			n_results++;
			seen = '{result_ch.ppm_level, result_ch.busy_res, result_ch.frame_number,
				result_ch.frame_end};
			if (train_exp_q.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("tb_top: unexpected result: lvl %0b busy %0b frame %0d end %0b",
						seen.ppm_level, seen.busy_res, seen.frame_number, seen.frame_end);
			end else begin
				want_r = train_exp_q.pop_front();
				if (seen !== want_r) begin
					n_err++;
					if (n_err <= 10)
						$display("tb_top: result %0d lvl/busy/frame/end: exp %0b/%0b/%0d/%0b",
							n_results, want_r.ppm_level, want_r.busy_res,
							want_r.frame_number, want_r.frame_end,
							" got %0b/%0b/%0d/%0b", seen.ppm_level, seen.busy_res,
							seen.frame_number, seen.frame_end);
				end
			end
		end
	end

	task automatic settle();
		while (pending_beats.size() != 0 || train_exp_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= data;
		case (sel)
			REG_GAP_LEN:     gap_reg = data[GAP_W-1:0];
			REG_SYNC_LEN:    sync_reg = data;
			REG_PULSE_LEVEL: pol_reg = data[0];
			default: ;
		endcase
		n_cfg++;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int g;
		int s;
		int est;
		int n_tick;
		logic pl;
		item_ch.valid = 1'b0;
		item_ch.command = CMD_TICK;
		item_ch.channel_index = '0;
		item_ch.channel_value = '0;
		result_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_GAP_LEN;
		cfg_data = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			tbl_len[i] = CENTER_VALUE;
			sched_tbl[i] = CENTER_VALUE;
		end
		cur_tick = '0;
		cur_period = SYNC_RESET;
		frame_idx = 0;
		trk_run = 1'b0;
		trk_conn = 1'b0;
		gap_reg = GAP_RESET;
		sync_reg = SYNC_RESET;
		pol_reg = 1'b0;

		dir_tab = '{
			// idle after reset: pin released high
			'{0, REG_GAP_LEN, 16'd0, CMD_TICK, 3'd0, 14'd0, 1, IDLE_PIN},
			'{0, REG_GAP_LEN, 16'd0, CMD_NONE, 3'd0, 14'd0, 1, IDLE_PIN},
			'{0, REG_GAP_LEN, 16'd0, CMD_WRITE, 3'd0, 14'd0, 1, IDLE_PIN},
			'{0, REG_GAP_LEN, 16'd0, CMD_WRITE, 3'd7, 14'd16383, 1, IDLE_PIN},
			'{0, REG_GAP_LEN, 16'd0, CMD_WRITE, 3'd3, 14'h2AAA, 0, NO_PIN},
			'{0, REG_GAP_LEN, 16'd0, CMD_WRITE, 3'd5, 14'h1555, 0, NO_PIN},
			'{0, REG_GAP_LEN, 16'd0, CMD_START, 3'd0, 14'd0, 1, '{1'b0, 1'b1, 4'd1, 1'b0}},
			'{0, REG_GAP_LEN, 16'd0, CMD_TICK, 3'd0, 14'd0, 1, '{1'b0, 1'b1, 4'd1, 1'b0}},
			'{0, REG_GAP_LEN, 16'd0, CMD_NONE, 3'd0, 14'd0, 0, NO_PIN},
			// restart while busy
			'{0, REG_GAP_LEN, 16'd0, CMD_START, 3'd0, 14'd0, 1, '{1'b0, 1'b1, 4'd1, 1'b0}},
			'{1, REG_GAP_LEN, 16'd1, CMD_TICK, 3'd0, 14'd0, 0, NO_PIN},
			'{1, REG_SYNC_LEN, 16'd1, CMD_TICK, 3'd0, 14'd0, 0, NO_PIN},
			'{1, REG_PULSE_LEVEL, 16'd1, CMD_TICK, 3'd0, 14'd0, 0, NO_PIN},
			// one-tick first frame, boundary on the next tick
			'{0, REG_GAP_LEN, 16'd0, CMD_START, 3'd0, 14'd0, 1, '{1'b1, 1'b1, 4'd1, 1'b0}},
			'{0, REG_GAP_LEN, 16'd0, CMD_TICK, 3'd0, 14'd0, 1, '{1'b1, 1'b1, 4'd2, 1'b1}},
			'{0, REG_GAP_LEN, 16'd0, CMD_TICK, 3'd0, 14'd0, 1, '{1'b0, 1'b1, 4'd2, 1'b0}},
			'{0, REG_GAP_LEN, 16'd0, CMD_WRITE, 3'd1, 14'd0, 0, NO_PIN},
			'{1, REG_GAP_LEN, 16'd32767, CMD_TICK, 3'd0, 14'd0, 0, NO_PIN},
			'{1, REG_SYNC_LEN, 16'd65535, CMD_TICK, 3'd0, 14'd0, 0, NO_PIN},
			'{0, REG_GAP_LEN, 16'd0, CMD_START, 3'd0, 14'd0, 1, '{1'b1, 1'b1, 4'd1, 1'b0}},
			'{0, REG_GAP_LEN, 16'd0, CMD_TICK, 3'd0, 14'd0, 1, '{1'b1, 1'b1, 4'd1, 1'b0}},
			// level follows pulse_level at once
			'{1, REG_PULSE_LEVEL, 16'd0, CMD_TICK, 3'd0, 14'd0, 0, NO_PIN},
			'{0, REG_GAP_LEN, 16'd0, CMD_TICK, 3'd0, 14'd0, 1, '{1'b0, 1'b1, 4'd1, 1'b0}}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				settle();
				write_reg(dir_tab[i].sel, dir_tab[i].rval);
			end else begin
				queue_beat(dir_tab[i].cmd, dir_tab[i].idx, dir_tab[i].val, dir_tab[i].fixed,
					dir_tab[i].want);
			end
		end

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin g = 1; s = 1; pl = 1'b1; end
				1: begin g = 1; s = 1; pl = 1'b0; end
				2: begin g = 3; s = 7; pl = 1'b0; end
				3: begin g = 5; s = 2; pl = 1'b1; end
				default: begin
					g = $urandom_range(1, 4);
					s = $urandom_range(1, 12);
					pl = $urandom_range(0, 1);
				end
			endcase
			settle();
			write_reg(REG_GAP_LEN, CFG_DATA_W'(g));
			write_reg(REG_SYNC_LEN, CFG_DATA_W'(s));
			write_reg(REG_PULSE_LEVEL, CFG_DATA_W'(pl));
			// stall the output long enough to back up the input
			if (p == 2 || $urandom_range(0, 3) == 0)
				hold_req++;
			repeat ($urandom_range(1, 2)) begin
				repeat ($urandom_range(0, 2))
					queue_beat(CMD_W'($urandom_range(0, 3)), IDX_W'($urandom),
						VALUE_W'($urandom), 0, NO_PIN);
				for (int c = 0; c < CHANNELS; c++) begin
					if (sched_tbl[c] > 24 || $urandom_range(0, 3) != 0)
						queue_beat(CMD_WRITE, IDX_W'(c),
							($urandom_range(0, 7) == 0) ? VALUE_W'($urandom_range(6, 24))
							: VALUE_W'($urandom_range(0, 5)), 0, NO_PIN);
				end
				queue_beat(CMD_START, IDX_W'($urandom), VALUE_W'($urandom), 0, NO_PIN);
				est = 2 * s;
				for (int c = 0; c < CHANNELS; c++)
					est += sched_tbl[c] + g;
				n_tick = est + $urandom_range(1, 4);
				// cut some trains short so the next start lands mid-train
				if ($urandom_range(0, 3) == 0)
					n_tick = $urandom_range(1, est);
				for (int k = 0; k < n_tick; k++) begin
					if ($urandom_range(0, 19) == 0) begin
						if ($urandom_range(0, 1) == 0)
							queue_beat(CMD_NONE, IDX_W'($urandom), VALUE_W'($urandom), 0, NO_PIN);
						else
							queue_beat(CMD_WRITE, IDX_W'($urandom),
								VALUE_W'($urandom_range(0, 5)), 0, NO_PIN);
					end
					queue_beat(CMD_TICK, IDX_W'($urandom), VALUE_W'($urandom), 0, NO_PIN);
				end
			end
		end

		// widest registers: only the first part of each period is reached
		settle();
		write_reg(REG_GAP_LEN, 16'd32767);
		write_reg(REG_SYNC_LEN, 16'd65535);
		write_reg(REG_PULSE_LEVEL, CFG_DATA_W'($urandom_range(0, 1)));
		for (int c = 0; c < CHANNELS; c++)
			queue_beat(CMD_WRITE, IDX_W'(c), VALUE_W'($urandom), 0, NO_PIN);
		repeat (3) begin
			queue_beat(CMD_START, '0, '0, 0, NO_PIN);
			repeat ($urandom_range(8, 20))
				queue_beat(CMD_TICK, IDX_W'($urandom), VALUE_W'($urandom), 0, NO_PIN);
			queue_beat(CMD_WRITE, '0, '0, 0, NO_PIN);
		end

		while (pending_beats.size() != 0 || train_exp_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("tb_top: %0d beats in, %0d results checked, %0d period boundaries, %0d mismatches",
			n_beats, n_results, n_bounds, n_err);
		$display("tb_top: %0d train starts, %0d trains run to the stop, %0d register writes",
			n_starts, n_trains, n_cfg);
		if (n_err == 0 && train_exp_q.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
